/* hdl/bdhc_pkg.sv */
`default_nettype none

package bdhc_pkg;

	// Widths of the transaction fields and of the configuration port.
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int EV_W    = 4;

	// Default number of multiplexed button slots.
	localparam int MUX_SLOTS_DEF = 6;

	// Depth of the queue between the front and the back part.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROVISION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTORY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SNOOZE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COMBO     = 3'd4;

	// Configuration reset values in milliseconds.
	localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd30;
	localparam logic [CFG_W-1:0] PROVISION_RST = 16'd3000;
	localparam logic [CFG_W-1:0] FACTORY_RST   = 16'd10000;
	localparam logic [CFG_W-1:0] SNOOZE_RST    = 16'd1000;
	localparam logic [CFG_W-1:0] COMBO_RST     = 16'd2000;

	// Event codes.
	localparam logic [EV_W-1:0] EV_BRIGHT_UP    = 4'd0;
	localparam logic [EV_W-1:0] EV_BRIGHT_DOWN  = 4'd1;
	localparam logic [EV_W-1:0] EV_TEMP         = 4'd2;
	localparam logic [EV_W-1:0] EV_ANTIPOISON   = 4'd3;
	localparam logic [EV_W-1:0] EV_FACTORY      = 4'd4;
	localparam logic [EV_W-1:0] EV_PROVISION    = 4'd5;
	localparam logic [EV_W-1:0] EV_SHOW_IP      = 4'd6;
	localparam logic [EV_W-1:0] EV_SNOOZE_LONG  = 4'd7;
	localparam logic [EV_W-1:0] EV_SNOOZE_SHORT = 4'd8;
	localparam logic [EV_W-1:0] EV_ALARM_TOGGLE = 4'd9;

	// Fixed slot roles.
	localparam int SLOT_UP   = 1;
	localparam int SLOT_DOWN = 2;
	localparam int SLOT_ADDR = 5;

	// Event positions in a tick record, in delivery order.
	localparam int EVB_UP     = 0;
	localparam int EVB_DOWN   = 1;
	localparam int EVB_TEMP   = 2;
	localparam int EVB_ANTI   = 3;
	localparam int EVB_ADDR   = 4;
	localparam int EVB_SNOOZE = 5;
	localparam int EVB_COMBO  = 6;
	localparam int EV_SLOTS   = 7;

	// One tick's worth of pending events.
	typedef struct packed {
		logic [EV_SLOTS-1:0] mask;
		logic [EV_W-1:0]     addr_code;
		logic [EV_W-1:0]     snooze_code;
	} bdhc_rec_t;

endpackage

`default_nettype wire

/* hdl/bdhc_ifs.sv */
`default_nettype none

// Tick channel: timestamp and raw button levels.
interface bdhc_tick_if import bdhc_pkg::*; #(
	parameter int MUX_SLOTS = MUX_SLOTS_DEF
) ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] time_ms;
	logic [MUX_SLOTS:0] raw_levels;

	modport source (output valid, output time_ms, output raw_levels, input ready);
	modport sink (input valid, input time_ms, input raw_levels, output ready);
endinterface

// Event channel: one event per transaction.
interface bdhc_evt_if import bdhc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [EV_W-1:0] event_code;
	logic            last_event;

	modport source (output valid, output event_code, output last_event, input ready);
	modport sink (input valid, input event_code, input last_event, output ready);
endinterface

`default_nettype wire

/* hdl/bdhc_front.sv */
`default_nettype none

module bdhc_front import bdhc_pkg::*; #(
	parameter int MUX_SLOTS = MUX_SLOTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	bdhc_tick_if.sink                 tick,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 q_full,
	output logic                      push,
	output bdhc_rec_t                 push_rec
);

	localparam int NB  = MUX_SLOTS + 1;
	localparam int DED = MUX_SLOTS;

	logic [CFG_W-1:0] debounce_q, provision_q, factory_q, snooze_q, combo_hold_q;

	logic [NB-1:0]     raw_seen_q;
	logic [NB-1:0]     stable_q;
	logic [TIME_W-1:0] edge_time_q  [NB];
	logic [TIME_W-1:0] press_time_q [NB];
	logic [TIME_W-1:0] combo_start_q;
	logic              combo_active_q;
	logic              combo_done_q;

	logic              accept;
	logic [TIME_W-1:0] now;
	logic [NB-1:0]     raw;
	logic [NB-1:0]     is_edge;
	logic [NB-1:0]     commit;
	logic [NB-1:0]     stable_nx;
	logic [TIME_W-1:0] elapsed [NB];
	logic [TIME_W-1:0] held_addr;
	logic [TIME_W-1:0] held_ded;
	logic [TIME_W-1:0] combo_elapsed;
	logic              combo_both;
	logic              combo_fire;
	bdhc_rec_t         rec;

	// A tick is taken whenever the queue has room for its record.
	assign tick.ready = !q_full;
	assign accept     = tick.valid && !q_full;
	assign now        = tick.time_ms;
	assign raw        = tick.raw_levels;

	// Per-button debounce lanes, all evaluated in parallel.
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			is_edge[i]   = raw[i] != raw_seen_q[i];
			elapsed[i]   = now - edge_time_q[i];
			commit[i]    = !is_edge[i] && (elapsed[i] >= TIME_W'(debounce_q))
				&& (raw[i] != stable_q[i]);
			stable_nx[i] = commit[i] ? raw[i] : stable_q[i];
		end
	end

	// Hold times for the two buttons that act on release.
	assign held_addr = now - press_time_q[SLOT_ADDR];
	assign held_ded  = now - press_time_q[DED];

	// Joint hold of the two brightness buttons; a fresh hold starts at zero elapsed time.
	assign combo_both    = stable_nx[SLOT_UP] && stable_nx[SLOT_DOWN];
	assign combo_elapsed = now - combo_start_q;
	assign combo_fire    = combo_both && !combo_done_q
		&& (combo_active_q ? (combo_elapsed >= TIME_W'(combo_hold_q))
			: (combo_hold_q == '0));

	// Build the record of events caused by this tick.
	always_comb begin
		rec.mask                = '0;
		rec.mask[EVB_UP]        = commit[1] && raw[1];
		rec.mask[EVB_DOWN]      = commit[2] && raw[2];
		rec.mask[EVB_TEMP]      = commit[3] && raw[3];
		rec.mask[EVB_ANTI]      = commit[4] && raw[4];
		rec.mask[EVB_ADDR]      = commit[SLOT_ADDR] && !raw[SLOT_ADDR];
		rec.mask[EVB_SNOOZE]    = commit[DED] && !raw[DED];
		rec.mask[EVB_COMBO]     = combo_fire;
		priority if (held_addr >= TIME_W'(factory_q)) begin
			rec.addr_code = EV_FACTORY;
		end else if (held_addr >= TIME_W'(provision_q)) begin
			rec.addr_code = EV_PROVISION;
		end else begin
			rec.addr_code = EV_SHOW_IP;
		end
		rec.snooze_code = (held_ded >= TIME_W'(snooze_q)) ? EV_SNOOZE_LONG : EV_SNOOZE_SHORT;
	end

	// Ticks that cause no event leave nothing in the queue.
	assign push     = accept && (rec.mask != '0);
	assign push_rec = rec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			provision_q  <= PROVISION_RST;
			factory_q    <= FACTORY_RST;
			snooze_q     <= SNOOZE_RST;
			combo_hold_q <= COMBO_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:  debounce_q   <= cfg_data;
				CFG_PROVISION: provision_q  <= cfg_data;
				CFG_FACTORY:   factory_q    <= cfg_data;
				CFG_SNOOZE:    snooze_q     <= cfg_data;
				CFG_COMBO:     combo_hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Button state update on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_seen_q <= '0;
			stable_q   <= '0;
			for (int i = 0; i < NB; i++) begin
				edge_time_q[i]  <= '0;
				press_time_q[i] <= '0;
			end
		end else if (accept) begin
			stable_q <= stable_nx;
			for (int i = 0; i < NB; i++) begin
				if (is_edge[i]) begin
					raw_seen_q[i]  <= raw[i];
					edge_time_q[i] <= now;
				end
				if (commit[i] && raw[i]) begin
					press_time_q[i] <= now;
				end
			end
		end
	end

	// Combo tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combo_start_q  <= '0;
			combo_active_q <= 1'b0;
			combo_done_q   <= 1'b0;
		end else if (accept) begin
			if (combo_both) begin
				combo_active_q <= 1'b1;
				if (!combo_active_q) begin
					combo_start_q <= now;
				end
				if (combo_fire) begin
					combo_done_q <= 1'b1;
				end
			end else begin
				combo_active_q <= 1'b0;
				combo_done_q   <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/bdhc_queue.sv */
`default_nettype none

module bdhc_queue import bdhc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire bdhc_rec_t push_rec,
	output logic           full,
	input  wire logic      pop,
	output logic           head_valid,
	output bdhc_rec_t      head_rec
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	bdhc_rec_t        ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_rec   = ent_q[rd_ptr_q];

	// Record storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/bdhc_back.sv */
`default_nettype none

module bdhc_back import bdhc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  wire bdhc_rec_t head_rec,
	output logic           pop,
	bdhc_evt_if.source     evt
);

	logic [EV_SLOTS-1:0] mask_q;
	logic [EV_W-1:0]     addr_code_q;
	logic [EV_W-1:0]     snooze_code_q;

	logic [EV_SLOTS-1:0] low_bit;
	logic [EV_SLOTS-1:0] rest;
	logic                done;
	logic                load;

	// Lowest pending event goes out first.
	assign low_bit = mask_q & (~mask_q + 1'b1);
	assign rest    = mask_q & ~low_bit;

	assign evt.valid      = mask_q != '0;
	assign evt.last_event = rest == '0;

	always_comb begin
		priority if (low_bit[EVB_UP]) begin
			evt.event_code = EV_BRIGHT_UP;
		end else if (low_bit[EVB_DOWN]) begin
			evt.event_code = EV_BRIGHT_DOWN;
		end else if (low_bit[EVB_TEMP]) begin
			evt.event_code = EV_TEMP;
		end else if (low_bit[EVB_ANTI]) begin
			evt.event_code = EV_ANTIPOISON;
		end else if (low_bit[EVB_ADDR]) begin
			evt.event_code = addr_code_q;
		end else if (low_bit[EVB_SNOOZE]) begin
			evt.event_code = snooze_code_q;
		end else begin
			evt.event_code = EV_ALARM_TOGGLE;
		end
	end

	// Take the next record when the current one is empty or its last event leaves.
	assign done = (mask_q == '0) || (evt.valid && evt.ready && evt.last_event);
	assign load = head_valid && done;
	assign pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= head_rec.mask;
		end else if (evt.valid && evt.ready) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_code_q   <= head_rec.addr_code;
			snooze_code_q <= head_rec.snooze_code;
		end
	end

endmodule

`default_nettype wire

/* hdl/button_debounce_hold_classifier_top.sv */
// Channel   Direction  Payload                         Transaction
// tick      in         time_ms[31:0], raw_levels       one sample of all buttons
// evt       out        event_code[3:0], last_event     one event
// cfg       in         cfg_index, cfg_data[15:0]       register write, no read-back
//
// The front part debounces all buttons of a tick in parallel and takes a new
// tick every cycle while the event queue (4 records) has room.
// A tick causes 0 to 7 events; the back part sends them one per cycle while the output
// does not stall. Ticks with no event put no record in the queue.
// Reset (arst_n low) clears all button state, the queue and loads default thresholds.
// The output may stall at will; a full queue drops tick.ready.
`default_nettype none

module button_debounce_hold_classifier_top import bdhc_pkg::*; #(
	parameter int MUX_SLOTS = MUX_SLOTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	bdhc_tick_if.sink                 tick,
	bdhc_evt_if.source                evt,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic      q_full;
	logic      push;
	bdhc_rec_t push_rec;
	logic      pop;
	logic      head_valid;
	bdhc_rec_t head_rec;

	// Debounce and classification.
	bdhc_front #(
		.MUX_SLOTS(MUX_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_rec  (push_rec)
	);

	// Record queue between the two parts.
	bdhc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	// Event serializer.
	bdhc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.evt        (evt)
	);

endmodule

`default_nettype wire

/* hdl/bdhc_checker.sv */
`default_nettype none

module bdhc_checker import bdhc_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            tick_ready,
	input wire logic            evt_valid,
	input wire logic            evt_ready,
	input wire logic [EV_W-1:0] event_code,
	input wire logic            last_event
);

	// A stalled event transaction keeps its payload.
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(event_code) && $stable(last_event))
		else $error("event changed while stalled");

	// Only defined event codes are sent.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> event_code <= EV_ALARM_TOGGLE)
		else $error("undefined event code");

	// The alarm toggle is always the final event of its tick.
	a_combo_last: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && event_code == EV_ALARM_TOGGLE |-> last_event)
		else $error("alarm toggle not last");

	// Only the alarm toggle may follow a snooze event of the same tick.
	a_snooze_next: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && !last_event
		&& (event_code == EV_SNOOZE_LONG || event_code == EV_SNOOZE_SHORT)
		|=> evt_valid && event_code == EV_ALARM_TOGGLE)
		else $error("unexpected event after snooze");

	// The queue is empty coming out of reset, so ticks are taken at once.
	a_ready_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> tick_ready)
		else $error("tick not ready after reset");

endmodule

bind button_debounce_hold_classifier_top bdhc_checker u_bdhc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_ready (tick.ready),
	.evt_valid  (evt.valid),
	.evt_ready  (evt.ready),
	.event_code (evt.event_code),
	.last_event (evt.last_event)
);

`default_nettype wire

/* bench/bdhc_event_monitor.sv */
`timescale 1ns / 1ps

// Watches the tick, event and configuration ports, predicts the events of each tick
// and compares them in order with the events that the block delivers.
module bdhc_event_monitor import bdhc_pkg::*; #(
	parameter int MUX_SLOTS = MUX_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bdhc_tick_if                 tick,
	bdhc_evt_if                  evt,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending_events
);

	localparam int NBTN        = MUX_SLOTS + 1;
	localparam int SLOT_TEMP   = 3;
	localparam int SLOT_ANTI   = 4;
	localparam int SLOT_SNOOZE = MUX_SLOTS;
	localparam int MAX_EVENTS  = 8;

	typedef struct packed {
		logic [EV_W-1:0] code;
		logic            last;
	} owed_evt_t;

	// Events still owed by the block, oldest first.
	owed_evt_t queued_events[$];

	// Thresholds as the block should hold them.
	logic [CFG_W-1:0] dbnc_lim;
	logic [CFG_W-1:0] prov_lim;
	logic [CFG_W-1:0] fact_lim;
	logic [CFG_W-1:0] snz_lim;
	logic [CFG_W-1:0] pair_lim;

	// Per-button debounce state and the joint hold of the brightness pair.
	logic [NBTN-1:0]   sampled_lvl;
	logic [NBTN-1:0]   committed_lvl;
	logic [TIME_W-1:0] edge_stamp [NBTN];
	logic [TIME_W-1:0] press_stamp [NBTN];
	logic [TIME_W-1:0] combo_since;
	logic              combo_armed;
	logic              combo_fired;

	owed_evt_t         got;
	owed_evt_t         want;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Debounces one tick, classifies the committed edges and queues the events in order.
	task automatic classify_tick(input logic [TIME_W-1:0] now, input logic [NBTN-1:0] lv);
		logic [EV_W-1:0]   codes[$];
		logic [TIME_W-1:0] elapsed;
		owed_evt_t         ev;
		for (int b = 0; b < NBTN; b++) begin
			elapsed = now - edge_stamp[b];
			if (lv[b] != sampled_lvl[b]) begin
				// A raw edge only restarts the window.
				sampled_lvl[b] = lv[b];
				edge_stamp[b]  = now;
			end else if (elapsed >= TIME_W'(dbnc_lim) && lv[b] != committed_lvl[b]) begin
				committed_lvl[b] = lv[b];
				if (lv[b]) begin
					press_stamp[b] = now;
					case (b)
						SLOT_UP:   codes.push_back(EV_BRIGHT_UP);
						SLOT_DOWN: codes.push_back(EV_BRIGHT_DOWN);
						SLOT_TEMP: codes.push_back(EV_TEMP);
						SLOT_ANTI: codes.push_back(EV_ANTIPOISON);
						default: ;
					endcase
				end else begin
					// Releases are sorted by how long the button was held.
					elapsed = now - press_stamp[b];
					if (b == SLOT_ADDR) begin
						if (elapsed >= TIME_W'(fact_lim)) codes.push_back(EV_FACTORY);
						else if (elapsed >= TIME_W'(prov_lim)) codes.push_back(EV_PROVISION);
						else codes.push_back(EV_SHOW_IP);
					end else if (b == SLOT_SNOOZE) begin
						if (elapsed >= TIME_W'(snz_lim)) codes.push_back(EV_SNOOZE_LONG);
						else codes.push_back(EV_SNOOZE_SHORT);
					end
				end
			end
		end

		// One alarm toggle per joint hold of both brightness buttons.
		if (committed_lvl[SLOT_UP] && committed_lvl[SLOT_DOWN]) begin
			if (!combo_armed) begin
				combo_armed = 1'b1;
				combo_since = now;
			end
			elapsed = now - combo_since;
			if (!combo_fired && elapsed >= TIME_W'(pair_lim)) begin
				combo_fired = 1'b1;
				codes.push_back(EV_ALARM_TOGGLE);
			end
		end else begin
			combo_armed = 1'b0;
			combo_since = '0;
			combo_fired = 1'b0;
		end

		for (int k = 0; k < codes.size() && k < MAX_EVENTS; k++) begin
			ev.code = codes[k];
			ev.last = (k == codes.size() - 1) || (k == MAX_EVENTS - 1);
			queued_events.push_back(ev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbnc_lim      = DEBOUNCE_RST;
			prov_lim      = PROVISION_RST;
			fact_lim      = FACTORY_RST;
			snz_lim       = SNOOZE_RST;
			pair_lim      = COMBO_RST;
			sampled_lvl   = '0;
			committed_lvl = '0;
			for (int b = 0; b < NBTN; b++) begin
				edge_stamp[b]  = '0;
				press_stamp[b] = '0;
			end
			combo_since = '0;
			combo_armed = 1'b0;
			combo_fired = 1'b0;
			queued_events.delete();
		end else begin
			// A tick transaction adds its events before any event of this edge is matched.
			if (tick.valid && tick.ready) begin
				classify_tick(tick.time_ms, tick.raw_levels);
			end

			// Each event transaction is matched against the oldest owed event.
			if (evt.valid && evt.ready) begin
				got.code = evt.event_code;
				got.last = evt.last_event;
				if (queued_events.size() == 0) begin
					report_mismatch($sformatf("event %0d delivered with none owed", got.code));
				end else begin
					want = queued_events.pop_front();
					if (got.code !== want.code) begin
						report_mismatch($sformatf("event_code %0d, wanted %0d", got.code, want.code));
					end
					if (got.last !== want.last) begin
						report_mismatch($sformatf("last_event %0b, wanted %0b on event %0d",
							got.last, want.last, want.code));
					end
				end
			end

			// Register writes; indexes past the last register are dropped.
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_DEBOUNCE:  dbnc_lim = cfg_data;
					CFG_PROVISION: prov_lim = cfg_data;
					CFG_FACTORY:   fact_lim = cfg_data;
					CFG_SNOOZE:    snz_lim  = cfg_data;
					CFG_COMBO:     pair_lim = cfg_data;
					default: ;
				endcase
			end
		end
		pending_events = queued_events.size();
	end

endmodule

/* bench/tb_button_debounce_hold_classifier_top.sv */
`timescale 1ns / 1ps

module tb_button_debounce_hold_classifier_top;
	import bdhc_pkg::*;

	localparam int MUX_SLOTS       = MUX_SLOTS_DEF;
	localparam int NBTN            = MUX_SLOTS + 1;
	localparam int MAX_GAP         = 18;
	localparam int QUIET_CYCLES    = 24;
	localparam int DRAIN_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int CHOKE_CYCLES    = 300;
	localparam int RANDOM_PHASES   = 7;
	localparam int TICKS_PER_PHASE = 45;
	localparam int CFG_IDX_MAX     = 2**CFG_IDX_W - 1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int fail_count;
	int pending_events;
	int idle_cycles;
	int choke_cycles;
	bit calm;

	// Stimulus time base, button levels and the scale of the current thresholds.
	logic [TIME_W-1:0] clock_ms;
	logic [NBTN-1:0]   levels_now;
	int                stim_debounce;
	int                stim_span;

	bdhc_tick_if #(.MUX_SLOTS(MUX_SLOTS)) tick_ch ();
	bdhc_evt_if evt_ch ();

	button_debounce_hold_classifier_top #(.MUX_SLOTS(MUX_SLOTS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.evt       (evt_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bdhc_event_monitor #(.MUX_SLOTS(MUX_SLOTS)) event_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick_ch),
		.evt            (evt_ch),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending_events (pending_events)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Offers one tick after a random gap and returns on the falling edge after its transaction.
	task automatic send_tick(input logic [TIME_W-1:0] stamp, input logic [NBTN-1:0] lv);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid      <= 1'b1;
		tick_ch.time_ms    <= stamp;
		tick_ch.raw_levels <= lv;
		do @(posedge clk); while (!tick_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Waits for the block to drain, then writes all thresholds plus one stray index.
	task automatic load_thresholds(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] p,
			input logic [CFG_W-1:0] f, input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] c);
		tick_ch.valid <= 1'b0;
		wait (pending_events == 0);
		repeat (QUIET_CYCLES) @(negedge clk);
		write_reg(CFG_DEBOUNCE, d);
		write_reg(CFG_PROVISION, p);
		write_reg(CFG_FACTORY, f);
		write_reg(CFG_SNOOZE, s);
		write_reg(CFG_COMBO, c);
		write_reg(CFG_IDX_W'($urandom_range(CFG_COMBO + 1, CFG_IDX_MAX)), CFG_W'($urandom));
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		stim_debounce = d;
		stim_span = p;
		if (f > stim_span) stim_span = f;
		if (s > stim_span) stim_span = s;
		if (c > stim_span) stim_span = c;
		stim_span = stim_span + 1;
	endtask

	// Random press and release traffic, with time steps scaled to the current thresholds.
	task automatic run_random_ticks(input int count);
		int r;
		int step;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 29) == 0) calm = ~calm;
			r = $urandom_range(0, 99);
			if (r < 10) step = 0;
			else if (r < 45) step = $urandom_range(0, 2 * stim_debounce + 2);
			else if (r < 85) step = $urandom_range(0, stim_span / 3);
			else step = $urandom_range(0, 2 * stim_span);
			// A few jumps land anywhere, backwards included.
			if (r >= 97) clock_ms = $urandom;
			else clock_ms = clock_ms + step;
			r = $urandom_range(0, 99);
			if (r < 30) levels_now[$urandom_range(0, NBTN - 1)] ^= 1'b1;
			else if (r < 36) levels_now = NBTN'($urandom);
			send_tick(clock_ms, levels_now);
		end
	endtask

	// Event sink: a random stall before each event, or one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (choke_cycles > 0) begin
				stall = choke_cycles;
				choke_cycles = 0;
			end else begin
				stall = calm ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (stall > 0) begin
				evt_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			evt_ch.ready <= 1'b1;
			do @(posedge clk); while (!evt_ch.valid);
			@(negedge clk);
		end
	end

	// Ends the run if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		tick_ch.valid      = 1'b0;
		tick_ch.time_ms    = '0;
		tick_ch.raw_levels = '0;
		evt_ch.ready       = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = CFG_DEBOUNCE;
		cfg_data           = '0;
		idle_cycles        = 0;
		choke_cycles       = 0;
		calm               = 1'b0;
		clock_ms           = '0;
		levels_now         = '0;
		stim_debounce      = DEBOUNCE_RST;
		stim_span          = FACTORY_RST + 1;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed ticks at the reset thresholds.
		send_tick(32'h0000_0000, 7'h00);
		// All buttons go down just before the clock wraps and commit just after it.
		send_tick(32'hFFFF_FFF0, 7'h7F);
		send_tick(32'h0000_0010, 7'h7F);
		// The joint brightness hold reaches the combo time exactly, then stays quiet.
		send_tick(32'd2016, 7'h7F);
		send_tick(32'd3000, 7'h7F);
		// Address and snooze buttons released after a provision-length hold.
		send_tick(32'd5000, 7'h1F);
		send_tick(32'd5030, 7'h1F);
		// A bounce that returns to the committed level emits nothing.
		send_tick(32'd5031, 7'h7F);
		send_tick(32'd5040, 7'h1F);
		send_tick(32'd5100, 7'h1F);
		// Short holds give show-address and a short snooze.
		send_tick(32'd6000, 7'h7F);
		send_tick(32'd6030, 7'h7F);
		send_tick(32'd6500, 7'h1F);
		send_tick(32'd6540, 7'h1F);
		// Long holds give factory reset and a long snooze.
		send_tick(32'd7000, 7'h7F);
		send_tick(32'd7030, 7'h7F);
		send_tick(32'd17030, 7'h1F);
		send_tick(32'd17060, 7'h1F);
		// Release everything, one millisecond short of the window and then on it.
		send_tick(32'd21000, 7'h00);
		send_tick(32'd21029, 7'h00);
		send_tick(32'd21030, 7'h00);
		// Time running backwards counts as a long wait.
		send_tick(32'd100, 7'h02);
		send_tick(32'd50, 7'h02);
		send_tick(32'd50, 7'h06);
		send_tick(32'd50, 7'h06);

		// Event-heavy ticks offered back to back while the sink holds off.
		calm = 1'b1;
		choke_cycles = CHOKE_CYCLES;
		clock_ms = 32'd30000;
		repeat (8) begin
			send_tick(clock_ms, 7'h1E);
			send_tick(clock_ms + 40, 7'h1E);
			send_tick(clock_ms + 60, 7'h00);
			send_tick(clock_ms + 100, 7'h00);
			clock_ms = clock_ms + 200;
		end
		calm = 1'b0;
		levels_now = '0;
		run_random_ticks(60);

		// Random traffic under zero, maximal and random thresholds.
		for (int p = 1; p <= RANDOM_PHASES; p++) begin
			case (p)
				1: load_thresholds('0, '0, '0, '0, '0);
				2: load_thresholds('1, '1, '1, '1, '1);
				3: load_thresholds('0, CFG_W'($urandom_range(0, 3000)),
					CFG_W'($urandom_range(0, 8000)), CFG_W'($urandom_range(0, 2000)),
					CFG_W'($urandom_range(0, 3000)));
				RANDOM_PHASES: load_thresholds(CFG_W'($urandom), CFG_W'($urandom),
					CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
				default: load_thresholds(CFG_W'($urandom_range(1, 40)),
					CFG_W'($urandom_range(0, 3000)), CFG_W'($urandom_range(0, 8000)),
					CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(0, 3000)));
			endcase
			run_random_ticks(TICKS_PER_PHASE);
		end

		// Drain and give the verdict.
		tick_ch.valid <= 1'b0;
		wait (pending_events == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/bdhc_pkg.sv
hdl/bdhc_ifs.sv
hdl/bdhc_front.sv
hdl/bdhc_queue.sv
hdl/bdhc_back.sv
hdl/button_debounce_hold_classifier_top.sv
hdl/bdhc_checker.sv
bench/bdhc_event_monitor.sv
bench/tb_button_debounce_hold_classifier_top.sv
